@@ rtl/swcc_pkg.sv @@
`default_nettype none

package swcc_pkg;

	// crc and conversion constants
	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  POLY_RESET  = 8'h31;
	localparam logic [7:0]  CRC_MSB     = 8'h80;
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] HUM_SPAN    = 14'd10000;
	localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

	// position of a byte within its triplet
	typedef enum logic [1:0] {
		POS_HIGH  = 2'd0,
		POS_LOW   = 2'd1,
		POS_CHECK = 2'd2
	} byte_pos_t;

	// one checked word handed from the framing stage to the converter
	typedef struct packed {
		logic [15:0] raw_word;
		logic        crc_ok;
		logic        word_index;
		logic        frame_done;
		logic        frame_error;
	} word_t;

	// one crc-8 byte step, msb first
	function automatic logic [7:0] crc8_step(
		input logic [7:0] crc,
		input logic [7:0] data,
		input logic [7:0] poly
	);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/swcc_frame.sv @@
`default_nettype none

module swcc_frame (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire logic [7:0]      poly,
	input  wire logic            in_valid,
	input  wire logic [7:0]      rx_byte,
	input  wire logic            last_in_frame,
	output logic                 valid_s1,
	output swcc_pkg::word_t      word_s1
);
	import swcc_pkg::*;

	byte_pos_t  pos_q;
	logic [7:0] crc_q;
	logic [7:0] high_q;
	logic [7:0] low_q;
	logic       count_q;
	logic       err_q;

	logic       accept;
	logic       is_check;
	logic [7:0] crc_next;
	logic       ok_now;
	logic       err_now;

	// transaction accepted whenever the pipeline moves
	assign accept   = in_valid & advance;
	assign is_check = (pos_q == POS_CHECK);
	assign crc_next = crc8_step(crc_q, rx_byte, poly);
	assign ok_now   = (crc_q == rx_byte);
	assign err_now  = err_q | ~ok_now;

	// triplet assembly, running crc and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HIGH;
			crc_q    <= CRC_INIT;
			high_q   <= 8'h00;
			low_q    <= 8'h00;
			count_q  <= 1'b0;
			err_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= accept & is_check;
			end
			if (accept) begin
				if (is_check) begin
					pos_q    <= POS_HIGH;
					crc_q    <= CRC_INIT;
					if (last_in_frame) begin
						count_q <= 1'b0;
						err_q   <= 1'b0;
					end else begin
						count_q <= 1'b1;
						err_q   <= err_now;
					end
				end else begin
					if (pos_q == POS_LOW) begin
						low_q <= rx_byte;
					end else begin
						high_q <= rx_byte;
					end
					// frame end on a data byte drops the partial triplet
					if (last_in_frame) begin
						pos_q   <= POS_HIGH;
						crc_q   <= CRC_INIT;
						count_q <= 1'b0;
						err_q   <= 1'b0;
					end else begin
						pos_q <= (pos_q == POS_LOW) ? POS_CHECK : POS_LOW;
						crc_q <= crc_next;
					end
				end
			end
		end
	end

	// checked word payload
	always_ff @(posedge clk) begin
		if (accept && is_check) begin
			word_s1.raw_word    <= {high_q, low_q};
			word_s1.crc_ok      <= ok_now;
			word_s1.word_index  <= count_q;
			word_s1.frame_done  <= last_in_frame;
			word_s1.frame_error <= err_now;
		end
	end

	// a frame end always returns to the first byte of a triplet
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_in_frame) |=> (pos_q == POS_HIGH && crc_q == CRC_INIT && !count_q))
		else $error("frame end did not clear triplet state");

	// a checksum byte always produces a word and restarts the crc
	a_check_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_check) |=> (valid_s1 && crc_q == CRC_INIT && pos_q == POS_HIGH))
		else $error("checksum byte did not emit a word");

	// data bytes never produce a word
	a_data_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !(accept && is_check)) |=> !valid_s1)
		else $error("word emitted without a checksum byte");

endmodule

`default_nettype wire

@@ rtl/swcc_convert.sv @@
`default_nettype none

module swcc_convert (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              valid_s1,
	input  wire swcc_pkg::word_t   word_s1,
	output logic                   out_valid,
	output logic [15:0]            raw_word,
	output logic                   crc_ok,
	output logic                   word_index,
	output logic signed [14:0]     temperature_centi,
	output logic [13:0]            humidity_centi,
	output logic                   frame_done,
	output logic                   frame_error
);
	import swcc_pkg::*;

	logic        valid_s2;
	word_t       word_s2;
	logic [30:0] temp_prod_s2;
	logic [29:0] hum_prod_s2;

	logic        out_valid_q;
	word_t       word_q;
	logic [14:0] temp_q;
	logic [13:0] hum_q;

	logic [14:0] temp_q0;
	logic [16:0] temp_rem;
	logic [14:0] temp_quot;
	logic [13:0] hum_q0;
	logic [16:0] hum_rem;
	logic [13:0] hum_quot;

	// divide by 65535: quotient estimate plus one correction step
	assign temp_q0   = temp_prod_s2[30:16];
	assign temp_rem  = 17'(temp_prod_s2[15:0]) + 17'(temp_q0);
	assign temp_quot = temp_q0 + 15'(temp_rem >= 17'(FULL_SCALE));
	assign hum_q0    = hum_prod_s2[29:16];
	assign hum_rem   = 17'(hum_prod_s2[15:0]) + 17'(hum_q0);
	assign hum_quot  = hum_q0 + 14'(hum_rem >= 17'(FULL_SCALE));

	// valid bits of the multiply and output stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// scale multiplies, then quotient and offset into the output register
	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2      <= word_s1;
			temp_prod_s2 <= 31'(word_s1.raw_word) * 31'(TEMP_SPAN);
			hum_prod_s2  <= 30'(word_s1.raw_word) * 30'(HUM_SPAN);
			word_q       <= word_s2;
			temp_q       <= temp_quot - TEMP_OFFSET;
			hum_q        <= hum_quot;
		end
	end

	assign out_valid         = out_valid_q;
	assign raw_word          = word_q.raw_word;
	assign crc_ok            = word_q.crc_ok;
	assign word_index        = word_q.word_index;
	assign temperature_centi = signed'(temp_q);
	assign humidity_centi    = hum_q;
	assign frame_done        = word_q.frame_done;
	assign frame_error       = word_q.frame_error;

	// converted values stay within the sensor scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hum_q <= HUM_SPAN))
		else $error("humidity out of range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (temperature_centi >= -16'sd4500 && temperature_centi <= 16'sd13000))
		else $error("temperature out of range");

	// a failed checksum is always reflected in the frame error
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !word_q.crc_ok) |-> word_q.frame_error)
		else $error("checksum failure missing from frame error");

endmodule

`default_nettype wire

@@ rtl/sensor_word_crc_check_convert.sv @@
// Checks and converts sensor response bytes.
// Input channel: one byte per transaction (rx_byte, last_in_frame), in_valid/in_stall.
// Bytes group as high data byte, low data byte, crc-8 byte (msb first, init 0xFF,
// polynomial from crc_polynomial, written with cfg_write; resets to 0x31).
// Output channel: one transaction per checksum byte with the 16-bit word, crc_ok,
// word_index, temperature and humidity in hundredths, frame_done and a sticky
// frame_error; out_valid/out_stall. Data bytes produce no output transaction.
// last_in_frame on a data byte drops the partial triplet and ends the frame.
// Pipeline: a checksum byte passes the framing and crc, scale multiply and divide
// correction registers in order; the last drives out_valid. Throughput: one byte
// per cycle while in_stall is low; the single byte-wide crc step and the pipeline
// advance set that figure. Write the polynomial only while idle; not enforced.
// Stall: while out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is high; otherwise every stage advances each cycle.
// Reset (arst_n low): triplet position, crc, frame state and all valid bits clear,
// so no output transaction is pending after reset.
`default_nettype none

module sensor_word_crc_check_convert (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [7:0]         crc_polynomial,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               last_in_frame,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             raw_word,
	output logic                    crc_ok,
	output logic                    word_index,
	output logic signed [14:0]      temperature_centi,
	output logic [13:0]             humidity_centi,
	output logic                    frame_done,
	output logic                    frame_error
);
	import swcc_pkg::*;

	logic       advance;
	logic [7:0] poly_q;
	logic       valid_s1;
	word_t      word_s1;

	// pipeline moves unless a finished transaction is held by the receiver
	assign advance  = ~(out_valid & out_stall);
	assign in_stall = ~advance;

	// polynomial register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
		end else if (cfg_write) begin
			poly_q <= crc_polynomial;
		end
	end

	swcc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.poly          (poly_q),
		.in_valid      (in_valid),
		.rx_byte       (rx_byte),
		.last_in_frame (last_in_frame),
		.valid_s1      (valid_s1),
		.word_s1       (word_s1)
	);

	swcc_convert u_convert (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.valid_s1          (valid_s1),
		.word_s1           (word_s1),
		.out_valid         (out_valid),
		.raw_word          (raw_word),
		.crc_ok            (crc_ok),
		.word_index        (word_index),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.frame_done        (frame_done),
		.frame_error       (frame_error)
	);

endmodule

`default_nettype wire

@@ dv/swcc_word_checker.sv @@
`default_nettype none

// crc-8 byte step for the word checker
package swcc_tb_pkg;

	function automatic logic [7:0] crc8_next(
		input logic [7:0] crc,
		input logic [7:0] data,
		input logic [7:0] poly
	);
		logic [7:0] c;
		logic       msb;
		c = crc ^ data;
		for (int n = 0; n < 8; n++) begin
			msb = c[7];
			c = c << 1;
			if (msb) begin
				c = c ^ poly;
			end
		end
		return c;
	endfunction

endpackage

// watches both channels, predicts each word and compares it
module swcc_word_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [7:0]         crc_polynomial,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               last_in_frame,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [15:0]        raw_word,
	input  wire logic               crc_ok,
	input  wire logic               word_index,
	input  wire logic signed [14:0] temperature_centi,
	input  wire logic [13:0]        humidity_centi,
	input  wire logic               frame_done,
	input  wire logic               frame_error,
	output int                      mismatch_count,
	output int                      words_pending
);
	import swcc_pkg::*;
	import swcc_tb_pkg::*;

	typedef struct {
		logic [15:0]        raw;
		logic               ok;
		logic               idx;
		logic signed [14:0] temp;
		logic [13:0]        hum;
		logic               done;
		logic               err;
	} sensor_word_t;

	sensor_word_t expected_words[$];

	// mirrored block state
	logic [7:0] poly;
	logic [7:0] crc;
	logic [7:0] hi_byte;
	logic [7:0] lo_byte;
	byte_pos_t  pos;
	logic       second_word;
	logic       err_sticky;
	int         fails = 0;

	// advance the framing state by one byte, queue a word on a checksum byte
	task automatic track_byte(input logic [7:0] b, input logic last);
		sensor_word_t w;
		logic [15:0]  raw;
		logic [31:0]  t_scaled;
		logic [31:0]  h_scaled;
		if (pos == POS_CHECK) begin
			raw = {hi_byte, lo_byte};
			t_scaled = 32'd17500 * raw / 32'd65535;
			h_scaled = 32'd10000 * raw / 32'd65535;
			w.raw = raw;
			w.ok = (crc == b);
			w.idx = second_word;
			w.temp = 15'(int'(t_scaled) - 4500);
			w.hum = 14'(h_scaled);
			w.done = last;
			w.err = err_sticky | ~w.ok;
			expected_words.push_back(w);
			pos = POS_HIGH;
			crc = CRC_INIT;
			if (last) begin
				second_word = 1'b0;
				err_sticky = 1'b0;
			end else begin
				second_word = 1'b1;
				err_sticky = w.err;
			end
		end else begin
			if (pos == POS_LOW) begin
				lo_byte = b;
			end else begin
				hi_byte = b;
			end
			crc = crc8_next(crc, b, poly);
			// a frame cut inside a triplet drops the partial word
			if (last) begin
				pos = POS_HIGH;
				crc = CRC_INIT;
				second_word = 1'b0;
				err_sticky = 1'b0;
			end else begin
				pos = (pos == POS_LOW) ? POS_CHECK : POS_LOW;
			end
		end
	endtask

	// compare one output transaction with the oldest expected word
	task automatic compare_word();
		sensor_word_t w;
		if (expected_words.size() == 0) begin
			fails++;
			if (fails <= 10) begin
				$display("unexpected word: raw %h ok %b idx %b temp %0d hum %0d done %b err %b",
					raw_word, crc_ok, word_index, temperature_centi, humidity_centi,
					frame_done, frame_error);
			end
		end else begin
			w = expected_words.pop_front();
			if (w.raw !== raw_word || w.ok !== crc_ok || w.idx !== word_index ||
				w.temp !== temperature_centi || w.hum !== humidity_centi ||
				w.done !== frame_done || w.err !== frame_error) begin
				fails++;
				if (fails <= 10) begin
					$display("word mismatch (exp/got): raw %h/%h ok %b/%b idx %b/%b",
						w.raw, raw_word, w.ok, crc_ok, w.idx, word_index);
					$display("  temp %0d/%0d hum %0d/%0d done %b/%b err %b/%b",
						w.temp, temperature_centi, w.hum, humidity_centi,
						w.done, frame_done, w.err, frame_error);
				end
			end
		end
	endtask

	// output first: a byte taken at this edge cannot come out at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly = POLY_RESET;
			crc = CRC_INIT;
			hi_byte = 8'h00;
			lo_byte = 8'h00;
			pos = POS_HIGH;
			second_word = 1'b0;
			err_sticky = 1'b0;
			expected_words.delete();
		end else begin
			if (out_valid && !out_stall) begin
				compare_word();
			end
			if (cfg_write) begin
				poly = crc_polynomial;
			end
			if (in_valid && !in_stall) begin
				track_byte(rx_byte, last_in_frame);
			end
		end
		mismatch_count <= fails;
		words_pending <= expected_words.size();
	end

endmodule

`default_nettype wire

@@ dv/sensor_word_crc_check_convert_tb.sv @@
`default_nettype none

module sensor_word_crc_check_convert_tb;
	import swcc_pkg::*;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [7:0]         crc_polynomial = POLY_RESET;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               last_in_frame = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        raw_word;
	logic               crc_ok;
	logic               word_index;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;
	logic               frame_done;
	logic               frame_error;

	int mismatch_count;
	int words_pending;

	// idle and stall rates in percent
	int idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;

	// sender view of the framing, used to form checksums
	logic [7:0] gen_poly = POLY_RESET;
	logic [7:0] gen_crc = CRC_INIT;
	byte_pos_t  gen_pos = POS_HIGH;

	sensor_word_crc_check_convert i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.crc_polynomial    (crc_polynomial),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.last_in_frame     (last_in_frame),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.raw_word          (raw_word),
		.crc_ok            (crc_ok),
		.word_index        (word_index),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.frame_done        (frame_done),
		.frame_error       (frame_error)
	);

	swcc_word_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.crc_polynomial    (crc_polynomial),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.last_in_frame     (last_in_frame),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.raw_word          (raw_word),
		.crc_ok            (crc_ok),
		.word_index        (word_index),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.frame_done        (frame_done),
		.frame_error       (frame_error),
		.mismatch_count    (mismatch_count),
		.words_pending     (words_pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// receiver backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// data byte biased toward the extremes
	function automatic logic [7:0] rand_data();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// one input transaction, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		last_in_frame <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (gen_pos == POS_CHECK) begin
			gen_pos = POS_HIGH;
			gen_crc = CRC_INIT;
		end else begin
			gen_crc = crc8_step(gen_crc, b, gen_poly);
			if (last) begin
				gen_pos = POS_HIGH;
				gen_crc = CRC_INIT;
			end else begin
				gen_pos = (gen_pos == POS_LOW) ? POS_CHECK : POS_LOW;
			end
		end
		bytes_sent++;
	endtask

	// finish the current triplet with the given word and a good or bad checksum
	task automatic send_triplet(input logic [15:0] word, input logic good, input logic last);
		if (gen_pos == POS_HIGH) begin
			send_byte(word[15:8], 1'b0);
		end
		if (gen_pos == POS_LOW) begin
			send_byte(word[7:0], 1'b0);
		end
		send_byte(good ? gen_crc : gen_crc ^ 8'($urandom_range(1, 255)), last);
	endtask

	// let every expected word come out and the pipeline settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_poly(input logic [7:0] value);
		wait_drained();
		cfg_write <= 1'b1;
		crc_polynomial <= value;
		gen_poly = value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// mostly well-formed frames, some cut short, some raw noise
	task automatic run_random(input int count);
		int target;
		int pick;
		int n_words;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				n_words = $urandom_range(1, 3);
				for (int w = 0; w < n_words; w++) begin
					send_triplet({rand_data(), rand_data()}, $urandom_range(99) < 85,
						w == n_words - 1);
				end
			end else if (pick < 90) begin
				if (gen_pos == POS_CHECK) begin
					send_triplet(16'h0000, 1'b1, 1'b0);
				end
				if ($urandom_range(1) == 1) begin
					send_byte(rand_data(), 1'b0);
				end
				send_byte(rand_data(), 1'b1);
			end else begin
				repeat ($urandom_range(1, 5)) begin
					send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
				end
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 6;
		stall_pct = 86;
		@(posedge clk);

		// frame of four words: index saturates, error sticks to the end of frame
		send_triplet(16'hBEEF, 1'b1, 1'b0);
		send_triplet(16'h0000, 1'b1, 1'b0);
		send_triplet(16'hFFFF, 1'b0, 1'b0);
		send_triplet(16'h6666, 1'b1, 1'b1);
		// fresh frame starts clean
		send_triplet(16'h8000, 1'b1, 1'b1);
		// frame cut on the high byte, then on the low byte
		send_byte(8'h55, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b1);
		send_triplet(16'h1234, 1'b0, 1'b1);
		// leave a triplet open across the polynomial change
		send_byte(8'hC3, 1'b0);

		write_poly(8'h00);
		run_random(380);

		idle_pct = 86;
		stall_pct = 6;
		write_poly(8'hFF);
		run_random(400);

		idle_pct = 0;
		stall_pct = 0;
		write_poly(8'($urandom_range(255)));
		run_random(400);

		write_poly(POLY_RESET);
		run_random(400);

		wait_drained();
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
